>>> sv/lbp_pkg.sv
// Shared constants, types and the pattern function of the 3x3 local binary pattern block.
package lbp_pkg;

	localparam int MAX_WIDTH    = 1024;
	localparam int MAX_CHANNELS = 3;
	localparam int HEIGHT_LIMIT = 4096;

	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int WREG_W     = 11;
	localparam int HREG_W     = 13;
	localparam int CREG_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int IN_ROW_W   = 13;
	localparam int OUT_ROW_W  = 12;
	localparam int SAMPLE_W   = 8;
	localparam int NUM_CH     = 3;
	localparam int PIX_W      = NUM_CH * SAMPLE_W;

	localparam logic [WREG_W-1:0] WIDTH_RESET  = WREG_W'(640);
	localparam logic [HREG_W-1:0] HEIGHT_RESET = HREG_W'(480);
	localparam logic [CREG_W-1:0] CHAN_RESET   = CREG_W'(1);

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_FLUSH = 1'b1;

	typedef logic [PIX_W-1:0]    pixel_t;
	typedef logic [SAMPLE_W-1:0] sample_t;

	// Everything the position logic decides about one word entering the window stage.
	typedef struct packed {
		logic             drain;
		logic             emit;
		logic             last;
		logic             top_ok;
		logic             bot_ok;
		logic             left_ok;
		logic             right_ok;
		logic [COL_W-1:0] col;
	} pos_info_t;

	// Window index is column * 3 + row; index 4 is the centre.
	function automatic sample_t lbp_code(input logic [8:0][SAMPLE_W-1:0] s,
		input logic top_ok, input logic bot_ok, input logic left_ok, input logic right_ok);
		logic [8:0]               okv;
		logic [8:0]               gt;
		logic [SAMPLE_W-1:0]      nb;
		okv = {bot_ok & right_ok, right_ok, top_ok & right_ok,
			bot_ok, 1'b1, top_ok,
			bot_ok & left_ok, left_ok, top_ok & left_ok};
		for (int k = 0; k < 9; k++) begin
			nb = okv[k] ? s[k] : '0;
			gt[k] = s[4] > nb;
		end
		return {gt[8], gt[7], gt[6], gt[5], gt[3], gt[2], gt[1], gt[0]};
	endfunction

endpackage

>>> sv/lbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lbp_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> sv/lbp_pos.sv
// Configuration registers and the input and output position counters.
module lbp_pos (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [lbp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lbp_pkg::CFG_DATA_W-1:0] cfg_wr_data,
	input  logic                         take,
	input  logic                         req_type,
	output logic                         kept,
	output lbp_pkg::pos_info_t           info,
	output logic [lbp_pkg::CREG_W-1:0]   chan_count
);
	import lbp_pkg::*;

	logic [WREG_W-1:0]    width_q;
	logic [HREG_W-1:0]    height_q;
	logic [CREG_W-1:0]    chan_q;
	logic [COL_W-1:0]     in_col_q;
	logic [IN_ROW_W-1:0]  in_row_q;
	logic [COL_W-1:0]     out_col_q;
	logic [OUT_ROW_W-1:0] out_row_q;

	logic [WREG_W-1:0] width_new;
	logic [HREG_W-1:0] height_new;
	logic [CREG_W-1:0] chan_new;
	logic [WREG_W-1:0] col_inc;
	logic [WREG_W-1:0] ocol_inc;
	logic [HREG_W-1:0] orow_inc;
	logic              col_wrap;
	logic              ocol_wrap;
	logic              drain;
	logic              emit;
	logic              last;

	always_comb begin
		width_new = cfg_wr_data[WREG_W-1:0];
		if (width_new == '0) begin
			width_new = WREG_W'(1);
		end else if (width_new > WREG_W'(MAX_WIDTH)) begin
			width_new = WREG_W'(MAX_WIDTH);
		end
		height_new = cfg_wr_data[HREG_W-1:0];
		if (height_new == '0) begin
			height_new = HREG_W'(1);
		end else if (height_new > HREG_W'(HEIGHT_LIMIT)) begin
			height_new = HREG_W'(HEIGHT_LIMIT);
		end
		chan_new = cfg_wr_data[CREG_W-1:0];
		if (chan_new == '0) begin
			chan_new = CREG_W'(1);
		end else if (chan_new > CREG_W'(MAX_CHANNELS)) begin
			chan_new = CREG_W'(MAX_CHANNELS);
		end
	end

	always_comb begin
		// Once every pixel row is in, any word (pixel or flush) pushes zeros to drain the window.
		drain     = in_row_q >= IN_ROW_W'(height_q);
		kept      = take && (drain || req_type == REQ_PIXEL);
		emit      = (in_row_q >= IN_ROW_W'(2)) || (in_row_q == IN_ROW_W'(1) && in_col_q != '0);
		col_inc   = {1'b0, in_col_q} + WREG_W'(1);
		col_wrap  = col_inc >= width_q;
		ocol_inc  = {1'b0, out_col_q} + WREG_W'(1);
		ocol_wrap = ocol_inc >= width_q;
		orow_inc  = {1'b0, out_row_q} + HREG_W'(1);
		last      = emit && orow_inc >= height_q && ocol_wrap;

		info.drain    = drain;
		info.emit     = emit;
		info.last     = last;
		info.top_ok   = out_row_q != '0;
		info.bot_ok   = orow_inc < height_q;
		info.left_ok  = out_col_q != '0;
		info.right_ok = !ocol_wrap;
		info.col      = in_col_q;
	end

	assign chan_count = chan_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= WIDTH_RESET;
			height_q  <= HEIGHT_RESET;
			chan_q    <= CHAN_RESET;
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_FRAME_WIDTH: begin
					width_q   <= width_new;
					in_col_q  <= '0;
					in_row_q  <= '0;
					out_col_q <= '0;
					out_row_q <= '0;
				end
				REG_FRAME_HEIGHT: begin
					height_q  <= height_new;
					in_col_q  <= '0;
					in_row_q  <= '0;
					out_col_q <= '0;
					out_row_q <= '0;
				end
				REG_CHANNEL_COUNT: begin
					chan_q <= chan_new;
				end
				default: begin
				end
			endcase
		end else if (kept) begin
			if (last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				in_col_q <= col_wrap ? '0 : col_inc[COL_W-1:0];
				if (col_wrap) begin
					in_row_q <= in_row_q + IN_ROW_W'(1);
				end
				if (emit) begin
					out_col_q <= ocol_wrap ? '0 : ocol_inc[COL_W-1:0];
					if (ocol_wrap) begin
						out_row_q <= out_row_q + OUT_ROW_W'(1);
					end
				end
			end
		end
	end

endmodule

>>> sv/lbp_core.sv
// Line stores, 3x3 window, pattern compare and the result register.
module lbp_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          kept,
	input  lbp_pkg::pos_info_t            info,
	input  logic [lbp_pkg::SAMPLE_W-1:0]  pixel_ch0,
	input  logic [lbp_pkg::SAMPLE_W-1:0]  pixel_ch1,
	input  logic [lbp_pkg::SAMPLE_W-1:0]  pixel_ch2,
	input  logic [lbp_pkg::CREG_W-1:0]    chan_count,
	input  logic                          out_stall,
	output logic                          in_stall,
	output logic                          out_valid,
	output logic [lbp_pkg::SAMPLE_W-1:0]  code_ch0,
	output logic [lbp_pkg::SAMPLE_W-1:0]  code_ch1,
	output logic [lbp_pkg::SAMPLE_W-1:0]  code_ch2,
	output logic                          last_of_frame
);
	import lbp_pkg::*;

	logic      s1_valid_q;
	pos_info_t info_s1;
	pixel_t    pix_s1;
	logic      fwd_s1;

	pixel_t pix_in;
	pixel_t up_rd;
	pixel_t mid_rd;
	pixel_t up_eff;
	pixel_t mid_eff;
	pixel_t upper_fwd_q;
	pixel_t middle_fwd_q;

	logic [8:0][PIX_W-1:0] win_q;
	logic [8:0][PIX_W-1:0] win_nxt;

	logic out_free;
	logic s1_adv;
	logic fwd_nxt;

	logic [NUM_CH-1:0][SAMPLE_W-1:0] code_nxt;
	logic [NUM_CH-1:0][SAMPLE_W-1:0] code_q;
	logic                            out_valid_q;
	logic                            last_q;

	assign pix_in = info.drain ? '0 : {pixel_ch2, pixel_ch1, pixel_ch0};

	// With a one-pixel row the next word reads the entry being written in the same cycle.
	assign up_eff  = fwd_s1 ? upper_fwd_q  : up_rd;
	assign mid_eff = fwd_s1 ? middle_fwd_q : mid_rd;

	assign out_free = !out_valid_q || !out_stall;
	assign s1_adv   = s1_valid_q && (!info_s1.emit || out_free);
	assign in_stall = s1_valid_q && !s1_adv;
	assign fwd_nxt  = s1_valid_q && s1_adv && info_s1.col == info.col;

	lbp_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper_store (
		.clk     (clk),
		.wr_en   (s1_adv),
		.wr_addr (info_s1.col),
		.wr_data (mid_eff),
		.rd_en   (kept),
		.rd_addr (info.col),
		.rd_data (up_rd)
	);

	lbp_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle_store (
		.clk     (clk),
		.wr_en   (s1_adv),
		.wr_addr (info_s1.col),
		.wr_data (pix_s1),
		.rd_en   (kept),
		.rd_addr (info.col),
		.rd_data (mid_rd)
	);

	always_comb begin
		win_nxt[5:0] = win_q[8:3];
		win_nxt[6]   = up_eff;
		win_nxt[7]   = mid_eff;
		win_nxt[8]   = pix_s1;
	end

	always_comb begin
		logic [8:0][SAMPLE_W-1:0] samp;
		for (int c = 0; c < NUM_CH; c++) begin
			for (int k = 0; k < 9; k++) begin
				samp[k] = win_nxt[k][c*SAMPLE_W +: SAMPLE_W];
			end
			if (CREG_W'(c) < chan_count) begin
				code_nxt[c] = lbp_code(samp, info_s1.top_ok, info_s1.bot_ok,
					info_s1.left_ok, info_s1.right_ok);
			end else begin
				code_nxt[c] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			win_q       <= '0;
		end else begin
			s1_valid_q <= kept || (s1_valid_q && !s1_adv);
			if (s1_adv) begin
				win_q <= win_nxt;
			end
			if (s1_adv && info_s1.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (kept) begin
			info_s1 <= info;
			pix_s1  <= pix_in;
			fwd_s1  <= fwd_nxt;
		end
		if (s1_adv) begin
			upper_fwd_q  <= mid_eff;
			middle_fwd_q <= pix_s1;
		end
		if (s1_adv && info_s1.emit) begin
			code_q <= code_nxt;
			last_q <= info_s1.last;
		end
	end

	assign out_valid     = out_valid_q;
	assign code_ch0      = code_q[0];
	assign code_ch1      = code_q[1];
	assign code_ch2      = code_q[2];
	assign last_of_frame = last_q;

endmodule

>>> sv/lbp_3x3_zero_padded.sv
// Each input word is registered in stage one, and its code is then held in the result register.
// The result of a pixel follows its input by one row plus one pixel of later input words.
// Throughput: one input word and one result word per cycle when out_stall is low, set by the
// line store read and the one-stage compare. Reset zeroes the position counters and
// window and loads width 640, height 480, one channel; the line stores are not cleared.
module lbp_3x3_zero_padded (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [lbp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lbp_pkg::CFG_DATA_W-1:0] cfg_wr_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           req_type,
	input  logic [lbp_pkg::SAMPLE_W-1:0]   pixel_ch0,
	input  logic [lbp_pkg::SAMPLE_W-1:0]   pixel_ch1,
	input  logic [lbp_pkg::SAMPLE_W-1:0]   pixel_ch2,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [lbp_pkg::SAMPLE_W-1:0]   code_ch0,
	output logic [lbp_pkg::SAMPLE_W-1:0]   code_ch1,
	output logic [lbp_pkg::SAMPLE_W-1:0]   code_ch2,
	output logic                           last_of_frame
);
	import lbp_pkg::*;

	logic              take;
	logic              kept;
	pos_info_t         info;
	logic [CREG_W-1:0] chan_count;

	assign take = in_valid && !in_stall;

	lbp_pos u_pos (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.take        (take),
		.req_type    (req_type),
		.kept        (kept),
		.info        (info),
		.chan_count  (chan_count)
	);

	lbp_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.kept          (kept),
		.info          (info),
		.pixel_ch0     (pixel_ch0),
		.pixel_ch1     (pixel_ch1),
		.pixel_ch2     (pixel_ch2),
		.chan_count    (chan_count),
		.out_stall     (out_stall),
		.in_stall      (in_stall),
		.out_valid     (out_valid),
		.code_ch0      (code_ch0),
		.code_ch1      (code_ch1),
		.code_ch2      (code_ch2),
		.last_of_frame (last_of_frame)
	);

endmodule

>>> tb/tb.sv
// Self-checking testbench of the 3x3 zero-padded local binary pattern block.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lbp_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int unsigned FULL_FRAME    = 32'hFFFF_FFFF;
	localparam int unsigned RANDOM_WORDS  = 700;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned QUIET_LIMIT   = 3000;

	typedef struct packed {
		sample_t ch0;
		sample_t ch1;
		sample_t ch2;
		logic    last;
	} lbp_word_t;

	// Tracks the line stores, the window and the frame position, and queues the codes due.
	class lbp_window_model;
		pixel_t      upper_line [MAX_WIDTH];
		pixel_t      middle_line [MAX_WIDTH];
		pixel_t      window [9];
		int unsigned in_col, in_row, out_col, out_row;
		int unsigned width, height, channels;
		lbp_word_t   pending_codes [$];
		int unsigned mismatches;
		int unsigned words_taken;

		function new();
			foreach (upper_line[i]) begin
				upper_line[i]  = '0;
				middle_line[i] = '0;
			end
			foreach (window[i]) window[i] = '0;
			restart();
			width       = WIDTH_RESET;
			height      = HEIGHT_RESET;
			channels    = CHAN_RESET;
			mismatches  = 0;
			words_taken = 0;
		endfunction

		function void restart();
			in_col  = 0;
			in_row  = 0;
			out_col = 0;
			out_row = 0;
		endfunction

		function int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
			if (v < lo)
				return lo;
			if (v > hi)
				return hi;
			return v;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
			REG_FRAME_WIDTH: begin
				width = clamp_to(data[WREG_W-1:0], 1, MAX_WIDTH);
				restart();
			end
			REG_FRAME_HEIGHT: begin
				height = clamp_to(data[HREG_W-1:0], 1, HEIGHT_LIMIT);
				restart();
			end
			REG_CHANNEL_COUNT: channels = clamp_to(data[CREG_W-1:0], 1, MAX_CHANNELS);
			default: ;
			endcase
		endfunction

		function void take_word(logic req, sample_t s0, sample_t s1, sample_t s2);
			pixel_t      pix, up, mid;
			int unsigned col, bitpos;
			logic        draining, emit, ok;
			sample_t     centre, nb;
			sample_t     codes [3];
			lbp_word_t   word;
			draining = (in_row >= height);
			// A flush inside the frame is dropped without touching any state.
			if (!draining && req == REQ_FLUSH)
				return;
			words_taken++;
			pix = draining ? '0 : {s2, s1, s0};
			col = in_col;
			up  = upper_line[col];
			mid = middle_line[col];
			upper_line[col]  = mid;
			middle_line[col] = pix;
			for (int i = 0; i < 6; i++) window[i] = window[i + 3];
			window[6] = up;
			window[7] = mid;
			window[8] = pix;
			emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
			in_col++;
			if (in_col >= width) begin
				in_col = 0;
				in_row++;
			end
			if (!emit)
				return;
			for (int c = 0; c < NUM_CH; c++) begin
				codes[c] = '0;
				if (c >= channels)
					continue;
				centre = window[4][SAMPLE_W*c +: SAMPLE_W];
				bitpos = 0;
				for (int kx = 0; kx < 3; kx++) begin
					for (int ky = 0; ky < 3; ky++) begin
						if (kx == 1 && ky == 1)
							continue;
						ok = !((ky == 0 && out_row < 1) || (ky == 2 && out_row + 1 >= height)
							|| (kx == 0 && out_col < 1) || (kx == 2 && out_col + 1 >= width));
						nb = ok ? window[kx*3 + ky][SAMPLE_W*c +: SAMPLE_W] : '0;
						if (centre > nb)
							codes[c][bitpos] = 1'b1;
						bitpos++;
					end
				end
			end
			word.ch0  = codes[0];
			word.ch1  = codes[1];
			word.ch2  = codes[2];
			word.last = (out_row + 1 >= height) && (out_col + 1 >= width);
			pending_codes.push_back(word);
			if (word.last) begin
				restart();
			end else begin
				out_col++;
				if (out_col >= width) begin
					out_col = 0;
					out_row++;
				end
			end
		endfunction

		function void check_word(lbp_word_t got);
			lbp_word_t want;
			if (pending_codes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR at %0t: unexpected code word %02h %02h %02h last=%0b",
						$time, got.ch0, got.ch1, got.ch2, got.last);
				return;
			end
			want = pending_codes.pop_front();
			if (got.ch0 !== want.ch0 || got.ch1 !== want.ch1 || got.ch2 !== want.ch2
				|| got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR at %0t: expected %02h %02h %02h last=%0b, got %02h %02h %02h last=%0b",
						$time, want.ch0, want.ch1, want.ch2, want.last,
						got.ch0, got.ch1, got.ch2, got.last);
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  req_type = REQ_PIXEL;
	sample_t               pixel_ch0 = '0;
	sample_t               pixel_ch1 = '0;
	sample_t               pixel_ch2 = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	sample_t               code_ch0, code_ch1, code_ch2;
	logic                  last_of_frame;

	lbp_window_model model = new();
	bit                    sender_idles = 1'b1;
	bit                    receiver_idles = 1'b1;
	bit                    long_hold_req = 1'b0;
	int unsigned           quiet_cycles = 0;

	lbp_3x3_zero_padded u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.req_type      (req_type),
		.pixel_ch0     (pixel_ch0),
		.pixel_ch1     (pixel_ch1),
		.pixel_ch2     (pixel_ch2),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.code_ch0      (code_ch0),
		.code_ch1      (code_ch1),
		.code_ch2      (code_ch2),
		.last_of_frame (last_of_frame)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Everything is sampled as it stood just before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wr_en)
				model.write_reg(cfg_index, cfg_wr_data);
			if (in_valid && !in_stall)
				model.take_word(req_type, pixel_ch0, pixel_ch1, pixel_ch2);
			if (out_valid && !out_stall)
				model.check_word({code_ch0, code_ch1, code_ch2, last_of_frame});
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		@(posedge clk);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (receiver_idles && $urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	task automatic send_word(input logic req, input sample_t s0, input sample_t s1,
		input sample_t s2);
		if (sender_idles && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		req_type  <= req;
		pixel_ch0 <= s0;
		pixel_ch1 <= s1;
		pixel_ch2 <= s2;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_pixel(input pixel_t px);
		send_word(REQ_PIXEL, px[7:0], px[15:8], px[23:16]);
	endtask

	task automatic send_noise_flush();
		send_word(REQ_FLUSH, $urandom_range(0, 255), $urandom_range(0, 255),
			$urandom_range(0, 255));
	endtask

	// Registers may only change once every code word due has come out.
	// The extra edge lets the monitor account for the last accepted word first.
	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
		in_valid <= 1'b0;
		@(posedge clk);
		while (model.pending_codes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_index   <= idx;
		cfg_wr_data <= CFG_DATA_W'(value);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	function automatic sample_t draw_sample(input int style);
		case (style)
		// Near the extremes, so that equal and off-by-one neighbors are common.
		1: return $urandom_range(0, 1) ? 8'hFF - $urandom_range(0, 1) : $urandom_range(0, 1);
		2: return $urandom_range(126, 130);
		default: return $urandom_range(0, 255);
		endcase
	endfunction

	// One frame of pixels with stray flushes, then enough pixel or flush words to drain it, unless cut at cut_at.
	task automatic send_frame(input int unsigned cut_at, input int style);
		int unsigned w, total;
		w     = model.width;
		total = model.width * model.height;
		for (int unsigned i = 0; i < total; i++) begin
			if (i == cut_at)
				return;
			if ($urandom_range(0, 15) == 0)
				send_noise_flush();
			send_word(REQ_PIXEL, draw_sample(style), draw_sample(style), draw_sample(style));
		end
		for (int unsigned i = 0; i <= w; i++) begin
			if ($urandom_range(0, 3) == 0)
				send_word(REQ_PIXEL, draw_sample(0), draw_sample(0), draw_sample(0));
			else
				send_noise_flush();
		end
		if ($urandom_range(0, 3) == 0)
			send_noise_flush();
	endtask

	initial begin
		pixel_t      corner_frame [9];
		int unsigned goal, tail_start, total, cut_at, value;
		bit          restart_due;
		corner_frame = '{24'h000000, 24'hFFFFFF, 24'h018000, 24'h8000FF, 24'h00FFFF,
			24'hFFFF01, 24'hFF0080, 24'h0001FF, 24'h80FF00};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: a 3x3 frame with all channels, borders on every side.
		set_reg(REG_FRAME_WIDTH, 3);
		set_reg(REG_FRAME_HEIGHT, 3);
		set_reg(REG_CHANNEL_COUNT, 3);
		set_reg(REG_UNUSED, 13'h1ABC);
		send_word(REQ_FLUSH, 8'hFF, 8'hFF, 8'hFF);
		for (int i = 0; i < 9; i++) begin
			if (i == 4)
				send_word(REQ_FLUSH, 8'h55, 8'hAA, 8'h55);
			send_pixel(corner_frame[i]);
		end
		send_word(REQ_FLUSH, 8'h00, 8'h00, 8'h00);
		send_word(REQ_PIXEL, 8'hAA, 8'hAA, 8'hAA);
		send_word(REQ_FLUSH, 8'h00, 8'h00, 8'h00);
		send_word(REQ_FLUSH, 8'h00, 8'h00, 8'h00);
		send_word(REQ_FLUSH, 8'hFF, 8'h00, 8'hFF);

		// Zero written to width and channel count acts as one.
		set_reg(REG_CHANNEL_COUNT, 0);
		set_reg(REG_FRAME_WIDTH, 0);
		set_reg(REG_FRAME_HEIGHT, 2);
		send_pixel(24'hFFFFFF);
		send_pixel(24'h090700);
		send_word(REQ_FLUSH, 8'h00, 8'h00, 8'h00);
		send_word(REQ_PIXEL, 8'h12, 8'h34, 8'h56);

		// Widest row the line stores hold, reached through saturation; only the start of
		// its row is sent, and the next geometry write restarts it.
		set_reg(REG_CHANNEL_COUNT, 2);
		set_reg(REG_FRAME_WIDTH, 13'h07FF);
		set_reg(REG_FRAME_HEIGHT, 1);
		send_frame(40, 0);

		// Tallest frame, only its top rows; the next geometry write restarts it.
		set_reg(REG_CHANNEL_COUNT, 13'h1FFF);
		set_reg(REG_FRAME_WIDTH, 3);
		set_reg(REG_FRAME_HEIGHT, 13'h1FFF);
		send_frame(15, 0);
		restart_due = 1'b1;

		// The first random frame runs against a long hold on the result side.
		set_reg(REG_FRAME_WIDTH, 24);
		set_reg(REG_FRAME_HEIGHT, 4);
		restart_due   = 1'b0;
		long_hold_req = 1'b1;
		send_frame(FULL_FRAME, 0);

		goal       = model.words_taken + RANDOM_WORDS;
		tail_start = goal - RANDOM_WORDS / 6;
		while (model.words_taken < goal) begin
			if (model.words_taken >= tail_start) begin
				sender_idles   = 1'b0;
				receiver_idles = 1'b0;
			end
			if (restart_due || $urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 9))
				0: value = 0;
				8: value = $urandom_range(9, 40);
				// Bits above the width register are dropped.
				9: value = ($urandom_range(1, 3) << WREG_W) | $urandom_range(1, 6);
				default: value = $urandom_range(1, 8);
				endcase
				set_reg(REG_FRAME_WIDTH, value);
				if ($urandom_range(0, 1))
					set_reg(REG_FRAME_HEIGHT, $urandom_range(0, 5));
				if ($urandom_range(0, 1))
					set_reg(REG_CHANNEL_COUNT, ($urandom_range(0, 2047) << 2) | $urandom_range(0, 3));
				restart_due = 1'b0;
			end
			total  = model.width * model.height;
			cut_at = FULL_FRAME;
			if ($urandom_range(0, 7) == 0) begin
				cut_at      = $urandom_range(0, total - 1);
				restart_due = 1'b1;
			end
			send_frame(cut_at, $urandom_range(0, 2));
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (model.pending_codes.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (model.mismatches == 0 && model.pending_codes.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
